>>> rtl/hmac_chain_log_verifier_unit_defines.svh
// Assertion macros for the log chain verifier.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef HMAC_CHAIN_LOG_VERIFIER_UNIT_DEFINES_SVH
`define HMAC_CHAIN_LOG_VERIFIER_UNIT_DEFINES_SVH

// Checked property, suspended while reset is asserted.
`define HCLV_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define HCLV_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/hclv_pkg.sv
// Shared types, constants and SHA-256 helpers for the log chain verifier.
// No dependencies; used by the interfaces, the hash core and the top level.
package hclv_pkg;

    // Message store and stream geometry.
    localparam int MAX_MSG_BYTES = 96;
    localparam int MSG_AW        = $clog2(MAX_MSG_BYTES);
    localparam int MLEN_W        = $clog2(MAX_MSG_BYTES + 1);
    localparam int PAD_BYTES     = 64;
    localparam int HDR_BYTES     = PAD_BYTES + 36;
    localparam int STREAM_MAX    = HDR_BYTES + MAX_MSG_BYTES;
    localparam int NBLK_MAX      = (STREAM_MAX + 72) / 64;
    localparam int BLK_W         = (NBLK_MAX > 1) ? $clog2(NBLK_MAX) : 1;
    localparam int POS_W         = BLK_W + 6;
    localparam int LEN_W         = $clog2(STREAM_MAX + 1);
    localparam int NBLK_W        = $clog2(NBLK_MAX + 1);
    localparam int LABEL_BYTES   = 12;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EVOLVE_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERIFY_MODE    = 3'd5;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ABSORB, ST_FILL, ST_START, ST_HASH, ST_PASS_END, ST_EMIT
    } hclv_state_t;

    typedef enum logic [1:0] {
        PASS_INNER, PASS_OUTER, PASS_EVO_INNER, PASS_EVO_OUTER
    } hclv_pass_t;

    // Control from the sequencer to the hash core.
    typedef struct packed {
        logic       init;
        logic       byte_en;
        logic [7:0] byte_val;
        logic       start;
    } sha_ctrl_t;

    // Status from the hash core.
    typedef struct packed {
        logic busy;
        logic done;
    } sha_stat_t;

    function automatic logic [7:0] label_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h63;
            4'd1:    b = 8'h65;
            4'd2:    b = 8'h6e;
            4'd3:    b = 8'h34;
            4'd4:    b = 8'h32;
            4'd5:    b = 8'h39;
            4'd6:    b = 8'h2d;
            4'd7:    b = 8'h65;
            4'd8:    b = 8'h76;
            4'd9:    b = 8'h72;
            4'd10:   b = 8'h69;
            4'd11:   b = 8'h6d;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/hclv_if.sv
// Channel interfaces: record chunks in, results out, configuration writes.
// Depends on hclv_pkg for the register index width.
interface hclv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] record_seq;
    logic [63:0] msg_chunk;
    logic [3:0]  chunk_bytes;
    logic        last_chunk;
    logic [63:0] stored_mac_0;
    logic [63:0] stored_mac_1;
    logic [63:0] stored_mac_2;
    logic [63:0] stored_mac_3;

    modport source (output valid, record_seq, msg_chunk, chunk_bytes, last_chunk,
                    stored_mac_0, stored_mac_1, stored_mac_2, stored_mac_3,
                    input ready);
    modport sink (input valid, record_seq, msg_chunk, chunk_bytes, last_chunk,
                  stored_mac_0, stored_mac_1, stored_mac_2, stored_mac_3,
                  output ready);
endinterface

interface hclv_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mac_out_0;
    logic [63:0] mac_out_1;
    logic [63:0] mac_out_2;
    logic [63:0] mac_out_3;
    logic        mac_match;
    logic        order_match;
    logic        log_intact;
    logic [15:0] records_done;

    modport source (output valid, mac_out_0, mac_out_1, mac_out_2, mac_out_3,
                    mac_match, order_match, log_intact, records_done,
                    input ready);
    modport sink (input valid, mac_out_0, mac_out_1, mac_out_2, mac_out_3,
                  mac_match, order_match, log_intact, records_done,
                  output ready);
endinterface

interface hclv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hclv_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/hclv_sha_core.sv
// SHA-256 compression unit: one round per cycle, message schedule in a shift line.
// Depends on hclv_pkg for the control and status structs and the round constants.
module hclv_sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  hclv_pkg::sha_ctrl_t ctrl,
    output hclv_pkg::sha_stat_t stat,
    output logic [255:0]        digest
);

    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [511:0] w_reg;
    logic [5:0]   rnd_reg;
    logic         run_reg;
    logic         add_reg;

    logic [31:0] t1, t2, w_new, big_s0, big_s1, ch, maj, ss0, ss1;

    // One round of the compression and the next schedule word.
    always_comb
    begin
        big_s1 = hclv_pkg::rotr(v_reg[4], 6) ^ hclv_pkg::rotr(v_reg[4], 11)
               ^ hclv_pkg::rotr(v_reg[4], 25);
        big_s0 = hclv_pkg::rotr(v_reg[0], 2) ^ hclv_pkg::rotr(v_reg[0], 13)
               ^ hclv_pkg::rotr(v_reg[0], 22);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_s1 + ch + hclv_pkg::round_const(rnd_reg) + w_reg[511:480];
        t2  = big_s0 + maj;
        ss0 = hclv_pkg::rotr(w_reg[479:448], 7) ^ hclv_pkg::rotr(w_reg[479:448], 18)
            ^ (w_reg[479:448] >> 3);
        ss1 = hclv_pkg::rotr(w_reg[63:32], 17) ^ hclv_pkg::rotr(w_reg[63:32], 19)
            ^ (w_reg[63:32] >> 10);
        w_new = w_reg[511:480] + ss0 + w_reg[223:192] + ss1;
    end

    // Round sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            add_reg <= 1'b0;
            rnd_reg <= '0;
        end
        else
        begin
            add_reg <= 1'b0;
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
        end
    end

    // Chaining value, working variables and schedule.
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= hclv_pkg::iv_word(3'(i));
            end
        end
        else if (add_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end

        if (ctrl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (run_reg)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end

        if (run_reg)
        begin
            w_reg <= {w_reg[479:0], w_new};
        end
        else if (ctrl.byte_en)
        begin
            w_reg <= {w_reg[503:0], ctrl.byte_val};
        end
    end

    assign stat.busy = run_reg | add_reg;
    assign stat.done = add_reg;
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

endmodule

>>> rtl/hmac_chain_log_verifier_unit.sv
// Top level: HMAC-SHA256 log chain verifier and generator with key evolution.
// A last chunk starts the hashing of 4 to 6 blocks, or 8 to 10 blocks with key evolution;
// each block is loaded into the round unit a byte a cycle and then compressed.
// The block takes one chunk at a time; the single shared SHA-256 round unit sets the rate.
// Reset clears key, chain MAC, sequence, counters and sets the intact flag; the message
// store has no reset, as only bytes of the current request's record are read.
module hmac_chain_log_verifier_unit (
    input  logic       clk,
    input  logic       rst_n,
    hclv_in_if.sink    rec_in,
    hclv_out_if.source res_out,
    hclv_cfg_if.sink   cfg
);

    `include "hmac_chain_log_verifier_unit_defines.svh"

    localparam int PW = hclv_pkg::POS_W;

    hclv_pkg::hclv_state_t state_reg, state_next;
    hclv_pkg::hclv_pass_t  pass_reg;
    hclv_pkg::sha_ctrl_t   sctrl;
    hclv_pkg::sha_stat_t   sstat;
    logic [255:0]          core_digest;

    // Chain state.
    logic [63:0] key_reg [4];
    logic [63:0] prev_mac_reg [4];
    logic [31:0] prev_seq_reg, cur_seq_reg;
    logic [hclv_pkg::MLEN_W-1:0] msg_len_reg;
    logic        open_reg, intact_reg, evolve_reg, verify_reg;
    logic [15:0] count_reg;

    // Latched request.
    logic [63:0]  chunk_reg;
    logic [3:0]   nb_reg, absorb_cnt_reg;
    logic         last_reg;
    logic [255:0] stored_reg;

    // Block fill and pass bookkeeping.
    logic [hclv_pkg::BLK_W-1:0] blk_reg;
    logic [6:0]   fill_cnt_reg;
    logic         byte_en_d_reg, from_mem_d_reg;
    logic [7:0]   byte_d_reg;
    logic [255:0] digest_reg, res_mac_reg;
    logic         res_mac_ok_reg, res_order_ok_reg;

    // Output register.
    logic         out_valid_reg;
    logic [255:0] out_mac_reg;
    logic         out_mac_ok_reg, out_order_ok_reg, out_intact_reg;
    logic [15:0]  out_count_reg;

    // Message store.
    logic [7:0] mem [hclv_pkg::MAX_MSG_BYTES];
    logic [7:0] mem_rdata_reg;
    logic       mem_we;
    logic [hclv_pkg::MSG_AW-1:0] mem_raddr;

    logic       absorb_done, in_fire, last_blk, pass_more, out_free;
    logic [hclv_pkg::LEN_W-1:0]  stream_len;
    logic [hclv_pkg::NBLK_W-1:0] nblk;
    logic [PW-1:0] pos;
    logic [7:0]    gen_byte;
    logic          gen_from_mem;
    logic [63:0]   len_bits;
    logic [7:0]    pad_byte;
    logic [3:0]    nb_clip;

    hclv_sha_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sctrl),
        .stat   (sstat),
        .digest (core_digest)
    );

    // Stream length of the current pass and its block count.
    always_comb
    begin
        unique case (pass_reg)
            hclv_pkg::PASS_INNER:
                stream_len = hclv_pkg::LEN_W'(hclv_pkg::HDR_BYTES) +
                             hclv_pkg::LEN_W'(msg_len_reg);
            hclv_pkg::PASS_EVO_INNER:
                stream_len = hclv_pkg::LEN_W'(hclv_pkg::PAD_BYTES + hclv_pkg::LABEL_BYTES);
            default:
                stream_len = hclv_pkg::LEN_W'(hclv_pkg::PAD_BYTES + 32);
        endcase
        nblk     = hclv_pkg::NBLK_W'((32'(stream_len) + 32'd72) >> 6);
        last_blk = (32'(blk_reg) == 32'(nblk) - 32'd1);
        len_bits = 64'(stream_len) << 3;
    end

    // Byte generator for position pos of the padded hash stream.
    always_comb
    begin
        pos = {blk_reg, fill_cnt_reg[5:0]};
        pad_byte = (pass_reg == hclv_pkg::PASS_INNER || pass_reg == hclv_pkg::PASS_EVO_INNER)
                   ? hclv_pkg::IPAD : hclv_pkg::OPAD;
        gen_from_mem = 1'b0;
        mem_raddr = hclv_pkg::MSG_AW'(pos - PW'(hclv_pkg::HDR_BYTES));
        priority if (last_blk && fill_cnt_reg[5:3] == 3'd7)
        begin
            gen_byte = len_bits[8*(7 - 32'(fill_cnt_reg[2:0])) +: 8];
        end
        else if (32'(pos) == 32'(stream_len))
        begin
            gen_byte = hclv_pkg::PAD_MARK;
        end
        else if (32'(pos) > 32'(stream_len))
        begin
            gen_byte = 8'h00;
        end
        else if (32'(pos) < 32)
        begin
            gen_byte = key_reg[pos[4:3]][8*(7 - 32'(pos[2:0])) +: 8] ^ pad_byte;
        end
        else if (32'(pos) < hclv_pkg::PAD_BYTES)
        begin
            gen_byte = pad_byte;
        end
        else if (pass_reg == hclv_pkg::PASS_EVO_INNER)
        begin
            gen_byte = hclv_pkg::label_byte(pos[3:0]);
        end
        else if (pass_reg != hclv_pkg::PASS_INNER)
        begin
            gen_byte = digest_reg[8*(31 - 32'(pos[4:0])) +: 8];
        end
        else if (32'(pos) < hclv_pkg::PAD_BYTES + 32)
        begin
            gen_byte = prev_mac_reg[pos[4:3]][8*(7 - 32'(pos[2:0])) +: 8];
        end
        else if (32'(pos) < hclv_pkg::HDR_BYTES)
        begin
            gen_byte = cur_seq_reg[8*(3 - 32'(pos[1:0])) +: 8];
        end
        else
        begin
            gen_byte = 8'h00;
            gen_from_mem = 1'b1;
        end
    end

    assign absorb_done = (absorb_cnt_reg == nb_reg);
    assign in_fire     = rec_in.valid && rec_in.ready;
    assign out_free    = !out_valid_reg || res_out.ready;
    assign pass_more   = (pass_reg == hclv_pkg::PASS_INNER) ||
                         (pass_reg == hclv_pkg::PASS_EVO_INNER) ||
                         (pass_reg == hclv_pkg::PASS_OUTER && evolve_reg);
    assign nb_clip     = (rec_in.chunk_bytes > 4'd8) ? 4'd8 : rec_in.chunk_bytes;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hclv_pkg::ST_IDLE:
                if (in_fire) state_next = hclv_pkg::ST_ABSORB;
            hclv_pkg::ST_ABSORB:
                if (absorb_done) state_next = last_reg ? hclv_pkg::ST_FILL : hclv_pkg::ST_IDLE;
            hclv_pkg::ST_FILL:
                if (fill_cnt_reg == 7'd64) state_next = hclv_pkg::ST_START;
            hclv_pkg::ST_START:
                state_next = hclv_pkg::ST_HASH;
            hclv_pkg::ST_HASH:
                if (sstat.done) state_next = last_blk ? hclv_pkg::ST_PASS_END : hclv_pkg::ST_FILL;
            hclv_pkg::ST_PASS_END:
                state_next = pass_more ? hclv_pkg::ST_FILL : hclv_pkg::ST_EMIT;
            hclv_pkg::ST_EMIT:
                if (out_free) state_next = hclv_pkg::ST_IDLE;
            default:
                state_next = hclv_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        rec_in.ready   = (state_reg == hclv_pkg::ST_IDLE);
        mem_we         = (state_reg == hclv_pkg::ST_ABSORB) && !absorb_done &&
                         (32'(msg_len_reg) < hclv_pkg::MAX_MSG_BYTES);
        sctrl.init     = ((state_reg == hclv_pkg::ST_ABSORB) && absorb_done && last_reg) ||
                         ((state_reg == hclv_pkg::ST_PASS_END) && pass_more);
        sctrl.byte_en  = byte_en_d_reg;
        sctrl.byte_val = from_mem_d_reg ? mem_rdata_reg : byte_d_reg;
        sctrl.start    = (state_reg == hclv_pkg::ST_START);
    end

    // Message store: one byte written and one read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[msg_len_reg[hclv_pkg::MSG_AW-1:0]] <= chunk_reg[8*(7 - 32'(absorb_cnt_reg[2:0])) +: 8];
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Control and chain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hclv_pkg::ST_IDLE;
            pass_reg       <= hclv_pkg::PASS_INNER;
            blk_reg        <= '0;
            fill_cnt_reg   <= '0;
            absorb_cnt_reg <= '0;
            byte_en_d_reg  <= 1'b0;
            open_reg       <= 1'b0;
            msg_len_reg    <= '0;
            cur_seq_reg    <= '0;
            prev_seq_reg   <= '0;
            intact_reg     <= 1'b1;
            count_reg      <= '0;
            evolve_reg     <= 1'b0;
            verify_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i]      <= '0;
                prev_mac_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index <= hclv_pkg::REG_KEY_WORD_3)
                    key_reg[cfg.index[1:0]] <= cfg.data;
                else if (cfg.index == hclv_pkg::REG_EVOLVE_ENABLE)
                    evolve_reg <= cfg.data[0];
                else if (cfg.index == hclv_pkg::REG_VERIFY_MODE)
                    verify_reg <= cfg.data[0];
            end

            // Chunk request taken in.
            if (in_fire)
            begin
                absorb_cnt_reg <= '0;
                if (!open_reg)
                begin
                    open_reg    <= 1'b1;
                    cur_seq_reg <= rec_in.record_seq;
                    msg_len_reg <= '0;
                end
            end

            // Bytes into the store.
            if (state_reg == hclv_pkg::ST_ABSORB && !absorb_done)
            begin
                absorb_cnt_reg <= absorb_cnt_reg + 4'd1;
                if (mem_we) msg_len_reg <= msg_len_reg + hclv_pkg::MLEN_W'(1);
            end

            if (state_reg == hclv_pkg::ST_ABSORB && absorb_done && last_reg)
            begin
                open_reg     <= 1'b0;
                pass_reg     <= hclv_pkg::PASS_INNER;
                blk_reg      <= '0;
                fill_cnt_reg <= '0;
            end

            // Block fill, one byte a cycle.
            byte_en_d_reg <= (state_reg == hclv_pkg::ST_FILL) && (fill_cnt_reg != 7'd64);
            if (state_reg == hclv_pkg::ST_FILL && fill_cnt_reg != 7'd64)
                fill_cnt_reg <= fill_cnt_reg + 7'd1;

            if (state_reg == hclv_pkg::ST_HASH && sstat.done && !last_blk)
            begin
                blk_reg      <= blk_reg + hclv_pkg::BLK_W'(1);
                fill_cnt_reg <= '0;
            end

            // End of a pass.
            if (state_reg == hclv_pkg::ST_PASS_END)
            begin
                blk_reg      <= '0;
                fill_cnt_reg <= '0;
                unique case (pass_reg)
                    hclv_pkg::PASS_INNER:     pass_reg <= hclv_pkg::PASS_OUTER;
                    hclv_pkg::PASS_OUTER:     pass_reg <= hclv_pkg::PASS_EVO_INNER;
                    hclv_pkg::PASS_EVO_INNER: pass_reg <= hclv_pkg::PASS_EVO_OUTER;
                    default:                  pass_reg <= hclv_pkg::PASS_INNER;
                endcase
                if (pass_reg == hclv_pkg::PASS_OUTER)
                begin
                    if (verify_reg)
                    begin
                        if (core_digest != stored_reg || cur_seq_reg != prev_seq_reg + 32'd1)
                            intact_reg <= 1'b0;
                        for (int i = 0; i < 4; i++)
                            prev_mac_reg[i] <= stored_reg[64*(3 - i) +: 64];
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                            prev_mac_reg[i] <= core_digest[64*(3 - i) +: 64];
                    end
                    prev_seq_reg <= cur_seq_reg;
                    if (count_reg != 16'hffff) count_reg <= count_reg + 16'd1;
                end
                if (pass_reg == hclv_pkg::PASS_EVO_OUTER)
                begin
                    for (int i = 0; i < 4; i++)
                        key_reg[i] <= core_digest[64*(3 - i) +: 64];
                end
            end

            // Result register.
            if (state_reg == hclv_pkg::ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            chunk_reg  <= rec_in.msg_chunk;
            nb_reg     <= nb_clip;
            last_reg   <= rec_in.last_chunk;
            stored_reg <= {rec_in.stored_mac_0, rec_in.stored_mac_1,
                           rec_in.stored_mac_2, rec_in.stored_mac_3};
        end
        byte_d_reg     <= gen_byte;
        from_mem_d_reg <= gen_from_mem;
        if (state_reg == hclv_pkg::ST_PASS_END)
        begin
            digest_reg <= core_digest;
            if (pass_reg == hclv_pkg::PASS_OUTER)
            begin
                res_mac_reg      <= core_digest;
                res_mac_ok_reg   <= verify_reg && (core_digest == stored_reg);
                res_order_ok_reg <= (cur_seq_reg == prev_seq_reg + 32'd1);
            end
        end
        if (state_reg == hclv_pkg::ST_EMIT && out_free)
        begin
            out_mac_reg      <= res_mac_reg;
            out_mac_ok_reg   <= res_mac_ok_reg;
            out_order_ok_reg <= res_order_ok_reg;
            out_intact_reg   <= intact_reg;
            out_count_reg    <= count_reg;
        end
    end

    assign cfg.ready            = 1'b1;
    assign res_out.valid        = out_valid_reg;
    assign res_out.mac_out_0    = out_mac_reg[255:192];
    assign res_out.mac_out_1    = out_mac_reg[191:128];
    assign res_out.mac_out_2    = out_mac_reg[127:64];
    assign res_out.mac_out_3    = out_mac_reg[63:0];
    assign res_out.mac_match    = out_mac_ok_reg;
    assign res_out.order_match  = out_order_ok_reg;
    assign res_out.log_intact   = out_intact_reg;
    assign res_out.records_done = out_count_reg;

    // The store never fills past its depth.
    `HCLV_CHECK(a_len_bound, 32'(msg_len_reg) <= hclv_pkg::MAX_MSG_BYTES, "message length overflow")
    // A start request always sets the round unit running.
    `HCLV_CHECK(a_start_runs, sctrl.start |=> sstat.busy, "round unit did not start")
    // Bytes are loaded into the schedule only while the round unit is idle.
    `HCLV_CHECK(a_load_idle, sctrl.byte_en |-> !sstat.busy, "schedule loaded while hashing")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the HMAC-SHA256 log chain verifier.
// Needs hclv_pkg, the channel interfaces and hmac_chain_log_verifier_unit.
`timescale 1ns / 100ps

module tb_top;

    // Latency allowance and the watchdog limit on cycles without any request.
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_CHUNKS  = 480;
    localparam int PRESSURE_HOLD  = 3000;
    localparam int MSG_LIMIT      = hclv_pkg::MAX_MSG_BYTES;

    localparam logic [2:0] CFG_KEY_WORD [4] = '{hclv_pkg::REG_KEY_WORD_0,
                                                hclv_pkg::REG_KEY_WORD_1,
                                                hclv_pkg::REG_KEY_WORD_2,
                                                hclv_pkg::REG_KEY_WORD_3};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // The twelve-byte label hashed to advance the key.
    localparam logic [95:0] EVOLVE_LABEL = 96'h63656e3432392d657672696d;

    typedef struct packed {
        logic [31:0]  seq;
        logic [63:0]  data;
        logic [3:0]   nbytes;
        logic         last;
        logic [255:0] stored;
    } chunk_t;

    typedef struct packed {
        logic [255:0] mac;
        logic         mac_ok;
        logic         order_ok;
        logic         intact;
        logic [15:0]  count;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hclv_in_if  rec ();
    hclv_out_if res ();
    hclv_cfg_if cfg ();

    hmac_chain_log_verifier_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (rec),
        .res_out (res),
        .cfg     (cfg)
    );

    // Chain state as the block should hold it.
    logic [255:0] chain_key;
    logic [255:0] chain_mac;
    logic [31:0]  chain_prev_seq;
    logic [31:0]  chain_seq;
    logic [7:0]   chain_msg [$];
    logic         chain_intact;
    logic [15:0]  chain_count;
    logic         chain_open;
    logic         evolve_on;
    logic         verify_on;

    verdict_t     pending_verdicts [$];
    int           mismatches = 0;
    int           chunks_sent = 0;
    int           verdicts_seen = 0;
    int           hold_len = 0;
    bit           quiet = 1'b0;
    int           idle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // SHA-256 digest of a byte string.
    function automatic logic [255:0] sha256_digest(input logic [7:0] d [$]);
        logic [31:0] h [8];
        logic [31:0] w [64];
        logic [31:0] a, b, c, e, f, g, hh, dd, t1, t2, s0, s1;
        logic [63:0] nbits;
        logic [255:0] out;
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        nbits = 64'(d.size()) * 8;
        d.push_back(8'h80);
        while (d.size() % 64 != 56)
            d.push_back(8'h00);
        for (int i = 7; i >= 0; i--)
            d.push_back(nbits[8*i +: 8]);
        for (int blk = 0; blk < d.size(); blk += 64)
        begin
            for (int i = 0; i < 16; i++)
                w[i] = {d[blk+4*i], d[blk+4*i+1], d[blk+4*i+2], d[blk+4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]}
                     ^ (w[i-15] >> 3);
                s1 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]}
                     ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = h[0]; b = h[1]; c = h[2]; dd = h[3];
            e = h[4]; f = h[5]; g = h[6]; hh = h[7];
            for (int i = 0; i < 64; i++)
            begin
                t1 = hh + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                     + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
                t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                     + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = dd + t1; dd = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += dd;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        end
        for (int i = 0; i < 8; i++)
            out[255-32*i -: 32] = h[i];
        return out;
    endfunction

    // HMAC-SHA256 with a 32-byte key.
    function automatic logic [255:0] hmac256(input logic [255:0] key, input logic [7:0] m [$]);
        logic [7:0]   inner_q [$];
        logic [7:0]   outer_q [$];
        logic [7:0]   kb;
        logic [255:0] inner;
        for (int i = 0; i < 64; i++)
        begin
            kb = (i < 32) ? key[255-8*i -: 8] : 8'h00;
            inner_q.push_back(kb ^ 8'h36);
            outer_q.push_back(kb ^ 8'h5c);
        end
        inner = sha256_digest({inner_q, m});
        for (int i = 0; i < 32; i++)
            outer_q.push_back(inner[255-8*i -: 8]);
        return sha256_digest(outer_q);
    endfunction

    // MAC of a record under the present chain key and chain MAC.
    function automatic logic [255:0] record_mac(input logic [31:0] seq, input logic [7:0] m [$]);
        logic [7:0] q [$];
        for (int i = 0; i < 32; i++)
            q.push_back(chain_mac[255-8*i -: 8]);
        for (int i = 3; i >= 0; i--)
            q.push_back(seq[8*i +: 8]);
        return hmac256(chain_key, {q, m});
    endfunction

    // Chain update for one accepted chunk; a last chunk yields a verdict.
    function automatic void absorb_chunk(input chunk_t ck);
        int           n;
        verdict_t     v;
        logic [7:0]   lbl [$];
        if (!chain_open)
        begin
            chain_seq = ck.seq;
            chain_msg.delete();
            chain_open = 1'b1;
        end
        n = (ck.nbytes > 8) ? 8 : int'(ck.nbytes);
        for (int i = 0; i < n; i++)
            if (chain_msg.size() < MSG_LIMIT)
                chain_msg.push_back(ck.data[63-8*i -: 8]);
        if (!ck.last)
            return;
        chain_open = 1'b0;
        v.mac = record_mac(chain_seq, chain_msg);
        v.order_ok = (chain_seq == chain_prev_seq + 32'd1);
        if (verify_on)
        begin
            v.mac_ok = (v.mac == ck.stored);
            if (!v.mac_ok || !v.order_ok)
                chain_intact = 1'b0;
            chain_mac = ck.stored;
        end
        else
        begin
            v.mac_ok = 1'b0;
            chain_mac = v.mac;
        end
        chain_prev_seq = chain_seq;
        if (chain_count != 16'hffff)
            chain_count++;
        if (evolve_on)
        begin
            for (int i = 11; i >= 0; i--)
                lbl.push_back(EVOLVE_LABEL[8*i +: 8]);
            chain_key = hmac256(chain_key, lbl);
        end
        v.intact = chain_intact;
        v.count = chain_count;
        pending_verdicts.push_back(v);
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Result receiver: random stalls, quiet stretches and one long hold-off.
    initial
    begin
        int stall;
        stall = 0;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                res.ready <= 1'b0;
                repeat (hold_len - 1) @(posedge clk);
                hold_len = 0;
            end
            else if (stall > 0)
            begin
                res.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Result checker against the oldest pending verdict.
    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{{res.mac_out_0, res.mac_out_1, res.mac_out_2, res.mac_out_3},
                    res.mac_match, res.order_match, res.log_intact, res.records_done};
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result, mac %h records %0d", got.mac, got.count);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result %0d expected mac %h match %b order %b intact %b n %0d",
                                 verdicts_seen, want.mac, want.mac_ok, want.order_ok,
                                 want.intact, want.count);
                        $display("       actual               mac %h match %b order %b intact %b n %0d",
                                 got.mac, got.mac_ok, got.order_ok, got.intact, got.count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge clk)
    begin
        if ((rec.valid && rec.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
            || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Register write; the chain state follows on acceptance.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        if (idx <= hclv_pkg::REG_KEY_WORD_3)
            chain_key[255-64*idx -: 64] = value;
        else if (idx == hclv_pkg::REG_EVOLVE_ENABLE)
            evolve_on = value[0];
        else if (idx == hclv_pkg::REG_VERIFY_MODE)
            verify_on = value[0];
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_chain(input logic [255:0] key, input bit evolve, input bit verify);
        for (int i = 0; i < 4; i++)
            write_reg(CFG_KEY_WORD[i], key[255-64*i -: 64]);
        write_reg(hclv_pkg::REG_EVOLVE_ENABLE, 64'(evolve));
        write_reg(hclv_pkg::REG_VERIFY_MODE, 64'(verify));
    endtask

    // Let every pending result arrive, then allow the block to settle.
    task automatic drain();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one chunk and hold it until the block takes it; valid then drops after each
    // request, for a gap that is sometimes drawn at random.
    task automatic send_chunk(input chunk_t ck);
        int gap;
        rec.valid        <= 1'b1;
        rec.record_seq   <= ck.seq;
        rec.msg_chunk    <= ck.data;
        rec.chunk_bytes  <= ck.nbytes;
        rec.last_chunk   <= ck.last;
        rec.stored_mac_0 <= ck.stored[255:192];
        rec.stored_mac_1 <= ck.stored[191:128];
        rec.stored_mac_2 <= ck.stored[127:64];
        rec.stored_mac_3 <= ck.stored[63:0];
        do @(posedge clk); while (!rec.ready);
        absorb_chunk(ck);
        chunks_sent++;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 1;
        rec.valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // One record: fixed_bytes < 0 picks chunk sizes at random.
    task automatic send_record(input int n_chunks, input bit seq_ok, input bit mac_ok,
                               input int fixed_bytes);
        chunk_t       cks [];
        logic [7:0]   m [$];
        logic [31:0]  seq;
        logic [255:0] good;
        int           n, kind;
        cks = new[n_chunks];
        seq = seq_ok ? chain_prev_seq + 32'd1 : $urandom;
        for (int c = 0; c < n_chunks; c++)
        begin
            kind = $urandom_range(0, 9);
            cks[c].seq = (c == 0) ? seq : $urandom;
            cks[c].data = (kind == 0) ? 64'd0 : (kind == 1) ? '1 : rand64();
            if (fixed_bytes >= 0)
                cks[c].nbytes = 4'(fixed_bytes);
            else
                cks[c].nbytes = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            cks[c].last = (c == n_chunks - 1);
            cks[c].stored = {rand64(), rand64(), rand64(), rand64()};
            n = (cks[c].nbytes > 8) ? 8 : int'(cks[c].nbytes);
            for (int i = 0; i < n; i++)
                if (m.size() < MSG_LIMIT)
                    m.push_back(cks[c].data[63-8*i -: 8]);
        end
        if (mac_ok)
        begin
            good = record_mac(seq, m);
            cks[n_chunks-1].stored = good;
        end
        foreach (cks[c])
            send_chunk(cks[c]);
    endtask

    // Reset defaults: verify mode, zero key; sizes from empty to over-long.
    task automatic test_reset_defaults();
        send_record(1, 1, 1, 0);
        send_record(1, 1, 1, 8);
        send_record(2, 1, 1, 15);
        send_record(13, 1, 1, 8);
        drain();
    endtask

    // Generate mode under all-ones and all-zero keys.
    task automatic test_generate_mode();
        setup_chain('1, 0, 0);
        send_record(1, 1, 0, 5);
        send_record(2, 1, 0, -1);
        drain();
        setup_chain('0, 0, 0);
        send_record(1, 0, 0, 3);
        drain();
    endtask

    // Key evolution after each record in both modes.
    task automatic test_key_evolution();
        setup_chain({rand64(), rand64(), rand64(), rand64()}, 1, 1);
        send_record(1, 1, 1, 8);
        send_record(1, 1, 1, 1);
        drain();
        write_reg(hclv_pkg::REG_VERIFY_MODE, 64'd0);
        send_record(2, 1, 0, -1);
        drain();
    endtask

    // Sequence wrap, then a forged MAC and an out-of-order record.
    task automatic test_sequence_and_tamper();
        setup_chain({rand64(), rand64(), rand64(), rand64()}, 0, 1);
        chain_prev_seq = chain_prev_seq;
        send_chunk('{32'hffff_ffff, rand64(), 4'd8, 1'b1, {4{rand64()}}});
        send_record(1, 1, 1, 8);
        send_record(1, 1, 0, 8);
        send_record(1, 0, 1, 8);
        drain();
    endtask

    // Receiver holds off for a long stretch while records keep coming.
    task automatic test_backpressure();
        hold_len = PRESSURE_HOLD;
        repeat (6) send_record(1, 1, 1, 8);
        drain();
    endtask

    // Random records over several settings, mostly well formed.
    task automatic test_random_records();
        int target, nch;
        target = chunks_sent + RANDOM_CHUNKS;
        for (int phase = 0; chunks_sent < target; phase++)
        begin
            quiet = (phase % 4 == 3);
            setup_chain({rand64(), rand64(), rand64(), rand64()}, phase[0], phase[1]);
            repeat (20)
            begin
                nch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
                send_record(nch, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, -1);
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rec.valid <= 1'b0;
        rec.record_seq <= '0;
        rec.msg_chunk <= '0;
        rec.chunk_bytes <= '0;
        rec.last_chunk <= 1'b0;
        rec.stored_mac_0 <= '0;
        rec.stored_mac_1 <= '0;
        rec.stored_mac_2 <= '0;
        rec.stored_mac_3 <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        chain_key = '0;
        chain_mac = '0;
        chain_prev_seq = '0;
        chain_seq = '0;
        chain_intact = 1'b1;
        chain_count = '0;
        chain_open = 1'b0;
        evolve_on = 1'b0;
        verify_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_generate_mode();
        test_key_evolution();
        test_sequence_and_tamper();
        test_backpressure();
        test_random_records();
        drain();

        $display("Summary: %0d chunks sent, %0d records checked across verify, generate",
                 chunks_sent, verdicts_seen);
        $display("         and key evolution settings, with stalls and one long hold-off.");
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
